// File: sv/pinalm_pkg.sv
// Package for the pin alarm controller.
// Holds mode, request and result codes plus register map and reset values.
// No dependencies.
`timescale 1ns / 1ps

package pinalm_pkg;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMING   = 2'd1,
    MODE_ARMED    = 2'd2,
    MODE_ALARM    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_KEY    = 2'd1,
    REQ_SENSOR = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CODE_NONE    = 2'd0,
    CODE_WRONG   = 2'd1,
    CODE_CORRECT = 2'd2,
    CODE_UNUSED  = 2'd3
  } code_res_e;

  localparam logic [2:0] ANN_NONE  = 3'd0;
  localparam logic [2:0] ANN_ARMED = 3'd6;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PASS_CODE   = 3'd0;
  localparam logic [2:0] REG_ARM_DELAY   = 3'd1;
  localparam logic [2:0] REG_ANN_STEP    = 3'd2;
  localparam logic [2:0] REG_ARMED_BLINK = 3'd3;
  localparam logic [2:0] REG_ALARM_BLINK = 3'd4;

  localparam int ADDR_W = 5;

  localparam logic [15:0] PASS_CODE_RST   = 16'h1234;
  localparam logic [12:0] ARM_DELAY_RST   = 13'd6000;
  localparam logic [12:0] ANN_STEP_RST    = 13'd1000;
  localparam logic [9:0]  ARMED_BLINK_RST = 10'd1000;
  localparam logic [9:0]  ALARM_BLINK_RST = 10'd40;

endpackage

// File: sv/pin_alarm_controller_core.sv
// Pin alarm controller top level: mode FSM, keypad code check, timers.
// Depends on pinalm_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o) carries one item per accept:
//   req_type_i selects a tick, a key press (key_code_i) or a door sensor
//   sample (sensor_bits_i). Every accepted item yields exactly one result
//   item on the output channel (out_valid_o / out_stall_i) with the mode,
//   the four indicator outputs, a countdown announcement and a code result.
//   The result is in the output register at the edge that accepts the item.
//   Throughput is one item per cycle while the receiver does not stall; all
//   decoding, counter updates and the code compare sit between the state
//   registers and the result register.
//   When the receiver stalls, the held result stays put and the input side
//   stalls in the same cycle; a taken result frees the register for the
//   item accepted at that same edge.
//   Reset puts the block in disarmed mode with all counters and lights
//   cleared and the configuration registers at their defaults. The user
//   writes config through the APB port only while no item is in flight; the block itself does not enforce it.
module pin_alarm_controller_core
  import pinalm_pkg::*;
#(
  parameter int CODE_DIGITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [3:0]        key_code_i,
  input  logic [1:0]        sensor_bits_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        mode_o,
  output logic              green_light_o,
  output logic              yellow_light_o,
  output logic              red_light_o,
  output logic              siren_on_o,
  output logic [2:0]        announce_o,
  output logic [1:0]        code_result_o
);

  localparam int CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [CNT_W-1:0] LastDigit = CNT_W'(CODE_DIGITS - 1);

  // ---------------- configuration ----------------
  logic [15:0] pass_code_q;
  logic [12:0] arm_delay_q;
  logic [12:0] ann_step_q;
  logic [9:0]  armed_blink_q;
  logic [9:0]  alarm_blink_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_code_q   <= PASS_CODE_RST;
      arm_delay_q   <= ARM_DELAY_RST;
      ann_step_q    <= ANN_STEP_RST;
      armed_blink_q <= ARMED_BLINK_RST;
      alarm_blink_q <= ALARM_BLINK_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PASS_CODE:   pass_code_q   <= pwdata[15:0];
        REG_ARM_DELAY:   arm_delay_q   <= pwdata[12:0];
        REG_ANN_STEP:    ann_step_q    <= pwdata[12:0];
        REG_ARMED_BLINK: armed_blink_q <= pwdata[9:0];
        REG_ALARM_BLINK: alarm_blink_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PASS_CODE:   prdata = {16'd0, pass_code_q};
      REG_ARM_DELAY:   prdata = {19'd0, arm_delay_q};
      REG_ANN_STEP:    prdata = {19'd0, ann_step_q};
      REG_ARMED_BLINK: prdata = {22'd0, armed_blink_q};
      REG_ALARM_BLINK: prdata = {22'd0, alarm_blink_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // ---------------- state ----------------
  mode_e       mode_q, mode_d;
  logic [3:0]  digit_q [CODE_DIGITS];   // no reset: written before read
  logic [CNT_W-1:0] dcnt_q, dcnt_d;
  logic [12:0] arm_cnt_q, arm_cnt_d;
  logic [9:0]  blink_q, blink_d;
  logic        yellow_q, yellow_d;
  logic        red_q, red_d;
  logic        key_we;

  // expected digit per position; positions beyond the 16-bit code read 0
  logic [3:0] exp_digit [CODE_DIGITS];
  for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_exp
    localparam int Pos = CODE_DIGITS - 1 - g;
    if (Pos < 4) begin : g_in
      assign exp_digit[g] = pass_code_q[4*Pos +: 4];
    end else begin : g_out
      assign exp_digit[g] = 4'd0;
    end
  end

  // code check: stored digits with the new key in the current slot
  logic code_match;
  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (dcnt_q == CNT_W'(i)) begin
        if (key_code_i != exp_digit[i]) code_match = 1'b0;
      end else if (digit_q[i] != exp_digit[i]) begin
        code_match = 1'b0;
      end
    end
  end

  // countdown announcement: compare against step * 1..5 (no divider)
  logic [12:0] arm_inc;
  logic [15:0] inc_w, m1, m2, m3, m4, m5;
  assign arm_inc = arm_cnt_q + 13'd1;
  assign inc_w   = {3'd0, arm_inc};
  assign m1      = {3'd0, ann_step_q};
  assign m2      = {m1[14:0], 1'b0};
  assign m4      = {m1[13:0], 2'b00};
  assign m3      = m2 + m1;
  assign m5      = m4 + m1;

  logic [9:0] blink_inc;
  assign blink_inc = blink_q + 10'd1;

  logic [2:0] ann_d;
  code_res_e  res_d;

  always_comb begin
    mode_d    = mode_q;
    dcnt_d    = dcnt_q;
    arm_cnt_d = arm_cnt_q;
    blink_d   = blink_q;
    yellow_d  = yellow_q;
    red_d     = red_q;
    ann_d     = ANN_NONE;
    res_d     = CODE_NONE;
    key_we    = 1'b0;
    case (req_e'(req_type_i))
      REQ_TICK: begin
        case (mode_q)
          MODE_ARMING: begin
            if (arm_inc == arm_delay_q) begin
              ann_d     = ANN_ARMED;
              mode_d    = MODE_ARMED;
              arm_cnt_d = '0;
              blink_d   = '0;
              yellow_d  = 1'b0;
            end else begin
              arm_cnt_d = arm_inc;
              if (ann_step_q != 13'd0) begin
                if (inc_w == m1)      ann_d = 3'd5;
                else if (inc_w == m2) ann_d = 3'd4;
                else if (inc_w == m3) ann_d = 3'd3;
                else if (inc_w == m4) ann_d = 3'd2;
                else if (inc_w == m5) ann_d = 3'd1;
              end
            end
          end
          MODE_ARMED: begin
            if (blink_inc == armed_blink_q) begin
              yellow_d = ~yellow_q;
              blink_d  = '0;
            end else begin
              blink_d  = blink_inc;
            end
          end
          MODE_ALARM: begin
            if (blink_inc == alarm_blink_q) begin
              red_d   = ~red_q;
              blink_d = '0;
            end else begin
              blink_d = blink_inc;
            end
          end
          default: ;
        endcase
      end
      REQ_KEY: begin
        if (mode_q == MODE_DISARMED || mode_q == MODE_ALARM) begin
          key_we = 1'b1;
          if (dcnt_q == LastDigit) begin
            dcnt_d = '0;
            if (code_match) begin
              res_d = CODE_CORRECT;
              if (mode_q == MODE_DISARMED) begin
                mode_d    = MODE_ARMING;
                arm_cnt_d = '0;
              end else begin
                mode_d  = MODE_DISARMED;
                red_d   = 1'b0;
                blink_d = '0;
              end
            end else begin
              res_d = CODE_WRONG;
            end
          end else begin
            dcnt_d = dcnt_q + CNT_W'(1);
          end
        end
      end
      REQ_SENSOR: begin
        if (mode_q == MODE_ARMED && sensor_bits_i != 2'd0) begin
          mode_d   = MODE_ALARM;
          yellow_d = 1'b0;
          red_d    = 1'b1;
          blink_d  = '0;
          dcnt_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_DISARMED;
      dcnt_q    <= '0;
      arm_cnt_q <= '0;
      blink_q   <= '0;
      yellow_q  <= 1'b0;
      red_q     <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      dcnt_q    <= dcnt_d;
      arm_cnt_q <= arm_cnt_d;
      blink_q   <= blink_d;
      yellow_q  <= yellow_d;
      red_q     <= red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && key_we) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (dcnt_q == CNT_W'(i)) digit_q[i] <= key_code_i;
      end
    end
  end

  // ---------------- result register ----------------
  logic [1:0] mode_out_q;
  logic       green_q, yellow_out_q, red_out_q, siren_q;
  logic [2:0] ann_q;
  logic [1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_out_q   <= mode_d;
      green_q      <= (mode_d == MODE_DISARMED) || (mode_d == MODE_ARMING);
      yellow_out_q <= (mode_d == MODE_ARMED) & yellow_d;
      red_out_q    <= (mode_d == MODE_ALARM) & red_d;
      siren_q      <= (mode_d == MODE_ALARM);
      ann_q        <= ann_d;
      res_q        <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mode_o         = mode_out_q;
  assign green_light_o  = green_q;
  assign yellow_light_o = yellow_out_q;
  assign red_light_o    = red_out_q;
  assign siren_on_o     = siren_q;
  assign announce_o     = ann_q;
  assign code_result_o  = res_q;

endmodule

// File: sv/pinalm_chk.sv
// Port-level checker for the pin alarm controller, bound to the top level.
// Depends on pinalm_pkg and pin_alarm_controller_core.
`timescale 1ns / 1ps

module pinalm_chk
  import pinalm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] mode_o,
  input logic       green_light_o,
  input logic       yellow_light_o,
  input logic       red_light_o,
  input logic       siren_on_o,
  input logic [2:0] announce_o,
  input logic [1:0] code_result_o
);

  // lights follow the reported mode
  a_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (green_light_o == (mode_o == MODE_DISARMED || mode_o == MODE_ARMING)) &&
      (siren_on_o == (mode_o == MODE_ALARM)) &&
      (!yellow_light_o || mode_o == MODE_ARMED) &&
      (!red_light_o || mode_o == MODE_ALARM))
    else $error("indicator outputs disagree with mode");

  // a correct code leaves the block arming or disarmed
  a_correct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && code_result_o == CODE_CORRECT) |->
      (mode_o == MODE_ARMING || mode_o == MODE_DISARMED))
    else $error("correct code with unexpected mode");

  // announcements only in countdown, armed message only once armed
  a_announce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && announce_o != ANN_NONE) |->
      ((announce_o == ANN_ARMED && mode_o == MODE_ARMED) ||
       (announce_o != ANN_ARMED && announce_o != 3'd7 && mode_o == MODE_ARMING)))
    else $error("announce out of place");

  // never a code result and an announcement on the same item
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (announce_o == ANN_NONE || code_result_o == CODE_NONE))
    else $error("announce and code result together");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(mode_o) && $stable(announce_o) &&
       $stable(code_result_o)))
    else $error("stalled result changed");

endmodule

bind pin_alarm_controller_core pinalm_chk u_pinalm_chk (.*);

// File: tb/sv/tb_pin_alarm_controller_core.sv
// Self-checking testbench for pin_alarm_controller_core: directed mode walks, config sweeps
// and mode-aware random items, checked against an in-bench alarm state tracker.
// Depends on pinalm_pkg and the pin_alarm_controller_core RTL.
`timescale 1ns / 1ps

module tb_pin_alarm_controller_core;
  import pinalm_pkg::*;

  localparam int          DIGITS      = 4;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic [3:0]  KEY_STAR    = 4'd10;
  localparam logic [3:0]  KEY_HASH    = 4'd11;

  // Everything the block reports for one item
  typedef struct packed {
    mode_e      mode;
    logic       green;
    logic       yellow;
    logic       red;
    logic       siren;
    logic [2:0] announce;
    code_res_e  code;
  } alarm_status_t;

  // Tracks the alarm state from accepted items and holds the statuses still due
  class alarm_tracker;
    logic [15:0]   pass_code;
    logic [12:0]   arm_delay;
    logic [12:0]   ann_step;
    logic [9:0]    armed_blink;
    logic [9:0]    alarm_blink;

    mode_e         mode_q;
    logic [3:0]    digits [DIGITS];
    int unsigned   digit_cnt;
    logic [12:0]   arm_cnt;
    logic [9:0]    blink_cnt;
    logic          yellow;
    logic          red;

    alarm_status_t status_due[$];
    int unsigned   errors;

    function new();
      pass_code   = PASS_CODE_RST;
      arm_delay   = ARM_DELAY_RST;
      ann_step    = ANN_STEP_RST;
      armed_blink = ARMED_BLINK_RST;
      alarm_blink = ALARM_BLINK_RST;
      mode_q      = MODE_DISARMED;
      foreach (digits[i]) digits[i] = 4'd0;
      digit_cnt   = 0;
      arm_cnt     = '0;
      blink_cnt   = '0;
      yellow      = 1'b0;
      red         = 1'b0;
      errors      = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_PASS_CODE:   pass_code   = val[15:0];
        REG_ARM_DELAY:   arm_delay   = val[12:0];
        REG_ANN_STEP:    ann_step    = val[12:0];
        REG_ARMED_BLINK: armed_blink = val[9:0];
        REG_ALARM_BLINK: alarm_blink = val[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction

    // Advance the alarm by one accepted item and queue the status it yields
    function void step_alarm(req_e req, logic [3:0] key, logic [1:0] sens);
      alarm_status_t st;
      logic [2:0]    ann;
      code_res_e     cres;
      int unsigned   j;
      bit            ok;
      ann  = ANN_NONE;
      cres = CODE_NONE;
      case (req)
        REQ_TICK: begin
          if (mode_q == MODE_ARMING) begin
            arm_cnt = arm_cnt + 13'd1;
            if (arm_cnt == arm_delay) begin
              // arming wins over any countdown value on the same tick
              ann       = ANN_ARMED;
              mode_q    = MODE_ARMED;
              arm_cnt   = '0;
              blink_cnt = '0;
              yellow    = 1'b0;
            end else if (ann_step != '0 && arm_cnt != '0 && arm_cnt % ann_step == '0) begin
              j = int'(arm_cnt / ann_step);
              if (j >= 1 && j <= 5) ann = 3'(6 - j);
            end
          end else if (mode_q == MODE_ARMED) begin
            blink_cnt = blink_cnt + 10'd1;
            if (blink_cnt == armed_blink) begin
              yellow    = ~yellow;
              blink_cnt = '0;
            end
          end else if (mode_q == MODE_ALARM) begin
            blink_cnt = blink_cnt + 10'd1;
            if (blink_cnt == alarm_blink) begin
              red       = ~red;
              blink_cnt = '0;
            end
          end
        end
        REQ_KEY: begin
          if (mode_q == MODE_DISARMED || mode_q == MODE_ALARM) begin
            if (digit_cnt < DIGITS) digits[digit_cnt] = key;
            digit_cnt++;
            if (digit_cnt >= DIGITS) begin
              ok = 1'b1;
              for (int i = 0; i < DIGITS; i++)
                if (digits[i] != pass_code[4*(DIGITS-1-i) +: 4]) ok = 1'b0;
              digit_cnt = 0;
              cres = ok ? CODE_CORRECT : CODE_WRONG;
              if (ok && mode_q == MODE_DISARMED) begin
                mode_q  = MODE_ARMING;
                arm_cnt = '0;
              end else if (ok) begin
                mode_q    = MODE_DISARMED;
                red       = 1'b0;
                blink_cnt = '0;
              end
            end
          end
        end
        REQ_SENSOR: begin
          if (mode_q == MODE_ARMED && sens != 2'b00) begin
            mode_q    = MODE_ALARM;
            yellow    = 1'b0;
            red       = 1'b1;
            blink_cnt = '0;
            digit_cnt = 0;
          end
        end
        default: ;  // unused request type leaves state alone
      endcase
      st.mode     = mode_q;
      st.green    = (mode_q == MODE_DISARMED || mode_q == MODE_ARMING);
      st.yellow   = (mode_q == MODE_ARMED) ? yellow : 1'b0;
      st.red      = (mode_q == MODE_ALARM) ? red : 1'b0;
      st.siren    = (mode_q == MODE_ALARM);
      st.announce = ann;
      st.code     = cres;
      status_due.push_back(st);
    endfunction

    function void check_status(alarm_status_t got);
      alarm_status_t exp;
      if (status_due.size() == 0) begin
        report($sformatf("unexpected result mode=%0d ann=%0d code=%0d",
                         got.mode, got.announce, got.code));
        return;
      end
      exp = status_due.pop_front();
      if (got !== exp)
        report($sformatf({"mode %0d/%0d grn %b/%b yel %b/%b red %b/%b sir %b/%b ",
                          "ann %0d/%0d code %0d/%0d (got/exp)"},
                         got.mode, exp.mode, got.green, exp.green, got.yellow, exp.yellow,
                         got.red, exp.red, got.siren, exp.siren, got.announce, exp.announce,
                         got.code, exp.code));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  logic [3:0]        key_code_i;
  logic [1:0]        sensor_bits_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        mode_o;
  logic              green_light_o;
  logic              yellow_light_o;
  logic              red_light_o;
  logic              siren_on_o;
  logic [2:0]        announce_o;
  logic [1:0]        code_result_o;

  alarm_tracker sb;
  bit           steady;          // set: no gaps on either side
  int unsigned  stall_left;
  int unsigned  cycle_cnt = 0;

  pin_alarm_controller_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .key_code_i     (key_code_i),
    .sensor_bits_i  (sensor_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mode_o         (mode_o),
    .green_light_o  (green_light_o),
    .yellow_light_o (yellow_light_o),
    .red_light_o    (red_light_o),
    .siren_on_o     (siren_on_o),
    .announce_o     (announce_o),
    .code_result_o  (code_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts, none when steady
  always @(negedge clk_i) begin
    if (steady || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Handshake monitor: inputs feed the tracker, outputs are checked in order.
  // The result is registered at the edge that accepts the item, so an item and its own result
  // never meet at the same edge.
  always @(posedge clk_i) begin
    alarm_status_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.step_alarm(req_e'(req_type_i), key_code_i, sensor_bits_i);
      if (out_valid_o && !out_stall_i) begin
        got.mode     = mode_e'(mode_o);
        got.green    = green_light_o;
        got.yellow   = yellow_light_o;
        got.red      = red_light_o;
        got.siren    = siren_on_o;
        got.announce = announce_o;
        got.code     = code_res_e'(code_result_o);
        sb.check_status(got);
      end
    end
  end

  // All driver tasks start and end at a falling edge.
  // The payload is held until the item is taken; the caller either sends
  // the next item in the same step or drops valid with hold_off.
  task automatic send_item(req_e req, logic [3:0] key, logic [1:0] sens);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    req_type_i    = req;
    key_code_i    = key;
    sensor_bits_i = sens;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++)
      send_item(REQ_TICK, 4'($urandom), 2'($urandom));
  endtask

  // Four keys, first digit from the top nibble
  task automatic send_code(logic [15:0] code);
    for (int i = DIGITS - 1; i >= 0; i--)
      send_item(REQ_KEY, code[4*i +: 4], 2'($urandom));
  endtask

  task automatic hold_off();
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    hold_off();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Config only changes with nothing in flight: the task drains first and then
  // idles past the single result register.
  task automatic set_config(logic [15:0] code, logic [12:0] delay, logic [12:0] step,
                            logic [9:0] yel_period, logic [9:0] red_period);
    drain();
    repeat (3) @(negedge clk_i);
    apb_write(REG_PASS_CODE,   32'(code));
    apb_write(REG_ARM_DELAY,   32'(delay));
    apb_write(REG_ANN_STEP,    32'(step));
    apb_write(REG_ARMED_BLINK, 32'(yel_period));
    apb_write(REG_ALARM_BLINK, 32'(red_period));
  endtask

  // Random items shaped by the tracked mode: mostly the right next digit
  // when a code is wanted, mostly ticks while counting, some sensor hits
  // while armed, and a share of noise everywhere.
  task automatic random_items(int n);
    req_e        req;
    logic [3:0]  key;
    logic [1:0]  sens;
    int unsigned roll;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2 || $urandom_range(0, 39) == 0) drain();
      roll = $urandom_range(0, 99);
      key  = 4'($urandom_range(0, 15));
      sens = 2'($urandom);
      case (sb.mode_q)
        MODE_DISARMED, MODE_ALARM: begin
          if (roll < 60) begin
            req = REQ_KEY;
            if ($urandom_range(0, 9) != 0)
              key = sb.pass_code[4*(DIGITS-1-sb.digit_cnt) +: 4];
          end else if (roll < 88) req = REQ_TICK;
          else if (roll < 95)     req = REQ_SENSOR;
          else                    req = REQ_NONE;
        end
        MODE_ARMING: begin
          if (roll < 88)      req = REQ_TICK;
          else if (roll < 94) req = REQ_KEY;
          else if (roll < 97) req = REQ_SENSOR;
          else                req = REQ_NONE;
        end
        default: begin
          if (roll < 85)      req = REQ_TICK;
          else if (roll < 95) req = REQ_SENSOR;
          else if (roll < 98) req = REQ_KEY;
          else                req = REQ_NONE;
        end
      endcase
      send_item(req, key, sens);
    end
  endtask

  initial begin
    logic [12:0] step;
    sb            = new();
    steady        = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_TICK;
    key_code_i    = 4'd0;
    sensor_bits_i = 2'b00;
    out_stall_i   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset defaults: idle requests, sensors while disarmed, wrong code
    // made of star, hash and out-of-range keys, then the real code.
    send_item(REQ_NONE, 4'hF, 2'b11);
    send_item(REQ_TICK, 4'h0, 2'b00);
    send_item(REQ_SENSOR, 4'h0, 2'b11);
    send_item(REQ_SENSOR, 4'h8, 2'b01);
    send_code({KEY_STAR, KEY_HASH, 4'd12, 4'd15});
    send_code(PASS_CODE_RST);
    // keys, sensors and idle requests do nothing while arming
    send_item(REQ_KEY, 4'd7, 2'b00);
    send_item(REQ_SENSOR, 4'd0, 2'b11);
    send_item(REQ_NONE, 4'd0, 2'b10);
    // start of the default countdown, no announcement yet
    send_ticks(40);
    // shorter countdown mid-way: 3, 2, 1 at 48, 64, 80, armed at 100
    set_config(PASS_CODE_RST, 13'd100, 13'd16, 10'd25, 10'd6);
    send_ticks(60);
    send_item(REQ_NONE, 4'd0, 2'b00);
    send_item(REQ_KEY, 4'd1, 2'b00);
    send_item(REQ_SENSOR, 4'd0, 2'b00);
    send_ticks(60);                       // yellow toggles twice
    send_item(REQ_SENSOR, 4'd0, 2'b10);   // one door trips the alarm
    send_item(REQ_KEY, 4'd1, 2'b00);
    send_item(REQ_KEY, 4'd2, 2'b00);
    send_item(REQ_KEY, 4'd3, 2'b00);
    send_ticks(15);                       // red blinks mid-entry
    send_item(REQ_KEY, 4'd9, 2'b00);      // completes a wrong code
    send_item(REQ_SENSOR, 4'd0, 2'b01);   // ignored in alarm
    send_code(PASS_CODE_RST);             // back to disarmed

    // Lowest settings: code of all zeros, everything fires on the first tick
    set_config(16'h0000, 13'd1, 13'd1, 10'd1, 10'd1);
    random_items(80);

    // Highest settings: all-ones code needs key 15, widest periods never fire
    set_config(16'hFFFF, 13'd8191, 13'd8191, 10'd1023, 10'd1023);
    send_code(16'hFFFF);
    send_ticks(30);
    // pull the arm point in so the block arms ten ticks later
    set_config(16'hFFFF, 13'd40, 13'd8191, 10'd1023, 10'd1023);
    send_ticks(20);
    send_item(REQ_SENSOR, 4'd0, 2'b01);
    send_ticks(20);
    send_code(16'hFFFF);
    random_items(30);

    // Random settings; the countdown often lands on a multiple of the step
    for (int p = 0; p < 3; p++) begin
      step = 13'($urandom_range(1, 12));
      set_config(16'($urandom), 13'(step * $urandom_range(1, 6) + $urandom_range(0, 2)),
                 step, 10'($urandom_range(1, 8)), 10'($urandom_range(1, 8)));
      if (p == 2) steady = 1'b1;          // last stretch runs without gaps
      random_items(50);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
